// File: hw/rtl/link_traffic_rate_monitor_top_macros.svh
// Assertion macros for the link traffic rate monitor.
`ifndef LINK_TRAFFIC_RATE_MONITOR_TOP_MACROS_SVH
`define LINK_TRAFFIC_RATE_MONITOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LTRM_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`define LTRM_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define LTRM_ASSERT_NOW(lbl, pre, post)
`define LTRM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: hw/rtl/ltrm_pkg.sv
package ltrm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_EVAL,
      ST_DONE
   } ltrm_state_type;

   typedef struct packed {
      logic load_item;
      logic accum;
      logic mul;
      logic prep;
      logic div_step;
      logic eval;
      logic emit;
   } ltrm_ctrl_type;

   localparam logic [1:0] REG_RATE_WINDOW = 2'd0;
   localparam logic [1:0] REG_CRIT_PCT    = 2'd1;
   localparam logic [1:0] REG_MISMATCH    = 2'd2;
   localparam logic [1:0] REG_DISC_TMO    = 2'd3;

   localparam logic [15:0] RATE_WINDOW_RST = 16'd1000;
   localparam logic [6:0]  CRIT_PCT_RST    = 7'd90;
   localparam logic [15:0] MISMATCH_RST    = 16'd32;
   localparam logic [31:0] DISC_TMO_RST    = 32'd5000;

   localparam logic [49:0] RATE_SCALE      = 50'd1000;
   localparam logic [30:0] PERCENT_SCALE   = 31'd100;
   localparam logic [15:0] RATIO_ONE       = 16'd16;
   localparam logic [15:0] RATIO_ONE_SIDED = 16'd15984;

   localparam logic [5:0]  DIV_STEPS       = 6'd32;

endpackage

// File: hw/rtl/link_traffic_rate_monitor_top.sv
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | tick, clear, rx/tx packet, push, blocked flags
// rsp     | out | rsp_valid/rsp_ready  | rates, totals, blocked counts, five flags
// csr     | in  | psel/penable/pwrite  | four registers at 4*i, pready tied high
//
// A word without a rate update passes the sequencer through accept, accumulate,
// evaluate and emit; its result is registered as it is emitted.
// A rate update adds two passes of one shared radix-2 divider, each made of scale,
// range check and 32 steps; a saturating pass ends at its check.
// A stalled result holds the sequencer in its emit state; no word is taken meanwhile.
// Reset is synchronous and clears all counters, rates and registers to defaults.
`include "link_traffic_rate_monitor_top_macros.svh"

module link_traffic_rate_monitor_top
   import ltrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_tick,
   input  logic        req_clear,
   input  logic        req_rx_valid,
   input  logic [15:0] req_rx_bytes,
   input  logic        req_tx_valid,
   input  logic [15:0] req_tx_bytes,
   input  logic        req_push_valid,
   input  logic [23:0] req_buffer_level,
   input  logic [23:0] req_buffer_size,
   input  logic        req_send_blocked,
   input  logic        req_recv_blocked,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_receive_rate,
   output logic [31:0] rsp_send_rate,
   output logic [47:0] rsp_total_received,
   output logic [47:0] rsp_total_sent,
   output logic [31:0] rsp_sends_blocked,
   output logic [31:0] rsp_receives_blocked,
   output logic        rsp_overflow_flag,
   output logic        rsp_mismatch_flag,
   output logic        rsp_sender_slow_flag,
   output logic        rsp_receiver_gone_flag,
   output logic        rsp_sender_gone_flag,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ltrm_state_type state_ff, state_in;
   ltrm_ctrl_type  ctrl;

   logic [15:0] rate_window_ff, rate_window_in;
   logic [6:0]  crit_pct_ff, crit_pct_in;
   logic [15:0] mismatch_ff, mismatch_in;
   logic [31:0] disc_tmo_ff, disc_tmo_in;

   logic        it_tick_ff, it_tick_in;
   logic        it_clear_ff, it_clear_in;
   logic        it_rxv_ff, it_rxv_in;
   logic [15:0] it_rxb_ff, it_rxb_in;
   logic        it_txv_ff, it_txv_in;
   logic [15:0] it_txb_ff, it_txb_in;
   logic        it_push_ff, it_push_in;
   logic [23:0] it_level_ff, it_level_in;
   logic [23:0] it_cap_ff, it_cap_in;
   logic        it_sblk_ff, it_sblk_in;
   logic        it_rblk_ff, it_rblk_in;

   logic [47:0] rx_total_ff, rx_total_in;
   logic [47:0] tx_total_ff, tx_total_in;
   logic [39:0] rx_window_ff, rx_window_in;
   logic [39:0] tx_window_ff, tx_window_in;
   logic [31:0] rx_rate_ff, rx_rate_in;
   logic [31:0] tx_rate_ff, tx_rate_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] since_send_ff, since_send_in;
   logic [31:0] since_recv_ff, since_recv_in;
   logic        pressure_ff, pressure_in;
   logic [31:0] blk_send_ff, blk_send_in;
   logic [31:0] blk_recv_ff, blk_recv_in;

   logic        side_tx_ff, side_tx_in;
   logic [30:0] level_prod_ff, level_prod_in;
   logic [30:0] cap_prod_ff, cap_prod_in;
   logic [49:0] div_num_ff, div_num_in;
   logic [31:0] div_rem_ff, div_rem_in;
   logic [31:0] div_quo_ff, div_quo_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic [35:0] mis_hi_ff, mis_hi_in;
   logic [47:0] mis_prod_ff, mis_prod_in;
   logic        both_zero_ff, both_zero_in;
   logic        one_zero_ff, one_zero_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_rx_rate_ff, o_rx_rate_in;
   logic [31:0] o_tx_rate_ff, o_tx_rate_in;
   logic [47:0] o_rx_total_ff, o_rx_total_in;
   logic [47:0] o_tx_total_ff, o_tx_total_in;
   logic [31:0] o_blk_send_ff, o_blk_send_in;
   logic [31:0] o_blk_recv_ff, o_blk_recv_in;
   logic        o_ovf_ff, o_ovf_in;
   logic        o_mis_ff, o_mis_in;
   logic        o_slow_ff, o_slow_in;
   logic        o_rgone_ff, o_rgone_in;
   logic        o_sgone_ff, o_sgone_in;

   logic        out_free;
   logic        rate_due;
   logic        div_sat;
   logic        div_last;
   logic        div_ge;
   logic [33:0] div_trial;
   logic        rate_write;
   logic [31:0] rate_value;
   logic [15:0] win;
   logic [48:0] rx_total_sum, tx_total_sum;
   logic [40:0] rx_window_sum, tx_window_sum;
   logic [39:0] div_bytes;
   logic [31:0] rate_hi, rate_lo;
   logic        csr_wr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign win       = (rate_window_ff == 16'd0) ? 16'd1 : rate_window_ff;
   assign div_sat   = {14'd0, div_num_ff[49:32]} >= elapsed_ff;
   assign div_last  = (div_cnt_ff == 6'd1);
   assign div_trial = {1'b0, div_rem_ff, div_quo_ff[31]} - {2'b00, elapsed_ff};
   assign div_ge    = !div_trial[33];
   assign rate_write = (ctrl.prep && div_sat) || (ctrl.div_step && div_last);
   assign rate_value = ctrl.prep ? 32'hFFFF_FFFF : {div_quo_ff[30:0], div_ge};
   assign div_bytes = side_tx_ff ? tx_window_ff : rx_window_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ACCUM;
         ST_ACCUM: state_in = rate_due ? ST_MUL : ST_EVAL;
         ST_MUL:   state_in = ST_PREP;
         ST_PREP: begin
            if (div_sat) state_in = side_tx_ff ? ST_EVAL : ST_MUL;
            else         state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = side_tx_ff ? ST_EVAL : ST_MUL;
         end
         ST_EVAL:  state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            ctrl.load_item = req_valid;
         end
         ST_ACCUM: ctrl.accum    = 1'b1;
         ST_MUL:   ctrl.mul      = 1'b1;
         ST_PREP:  ctrl.prep     = 1'b1;
         ST_DIV:   ctrl.div_step = 1'b1;
         ST_EVAL:  ctrl.eval     = 1'b1;
         ST_DONE:  ctrl.emit     = out_free;
         default: begin
            ctrl      = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         REG_RATE_WINDOW: prdata = {16'd0, rate_window_ff};
         REG_CRIT_PCT:    prdata = {25'd0, crit_pct_ff};
         REG_MISMATCH:    prdata = {16'd0, mismatch_ff};
         REG_DISC_TMO:    prdata = disc_tmo_ff;
         default:         prdata = 32'd0;
      endcase
   end

   always_comb begin
      rate_window_in = rate_window_ff;
      crit_pct_in    = crit_pct_ff;
      mismatch_in    = mismatch_ff;
      disc_tmo_in    = disc_tmo_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            REG_RATE_WINDOW: rate_window_in = pwdata[15:0];
            REG_CRIT_PCT:    crit_pct_in    = pwdata[6:0];
            REG_MISMATCH:    mismatch_in    = pwdata[15:0];
            REG_DISC_TMO:    disc_tmo_in    = pwdata;
            default:         disc_tmo_in    = disc_tmo_ff;
         endcase
      end
   end

   // word capture
   always_comb begin
      it_tick_in  = it_tick_ff;
      it_clear_in = it_clear_ff;
      it_rxv_in   = it_rxv_ff;
      it_rxb_in   = it_rxb_ff;
      it_txv_in   = it_txv_ff;
      it_txb_in   = it_txb_ff;
      it_push_in  = it_push_ff;
      it_level_in = it_level_ff;
      it_cap_in   = it_cap_ff;
      it_sblk_in  = it_sblk_ff;
      it_rblk_in  = it_rblk_ff;
      if (ctrl.load_item) begin
         it_tick_in  = req_tick;
         it_clear_in = req_clear;
         it_rxv_in   = req_rx_valid;
         it_rxb_in   = req_rx_bytes;
         it_txv_in   = req_tx_valid;
         it_txb_in   = req_tx_bytes;
         it_push_in  = req_push_valid;
         it_level_in = req_buffer_level;
         it_cap_in   = req_buffer_size;
         it_sblk_in  = req_send_blocked;
         it_rblk_in  = req_recv_blocked;
      end
   end

   // counters, totals and the shared divider
   always_comb begin
      rx_total_in   = rx_total_ff;
      tx_total_in   = tx_total_ff;
      rx_window_in  = rx_window_ff;
      tx_window_in  = tx_window_ff;
      rx_rate_in    = rx_rate_ff;
      tx_rate_in    = tx_rate_ff;
      elapsed_in    = elapsed_ff;
      since_send_in = since_send_ff;
      since_recv_in = since_recv_ff;
      pressure_in   = pressure_ff;
      blk_send_in   = blk_send_ff;
      blk_recv_in   = blk_recv_ff;
      side_tx_in    = side_tx_ff;
      level_prod_in = level_prod_ff;
      cap_prod_in   = cap_prod_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      mis_hi_in     = mis_hi_ff;
      mis_prod_in   = mis_prod_ff;
      both_zero_in  = both_zero_ff;
      one_zero_in   = one_zero_ff;
      rate_due      = 1'b0;
      rx_total_sum  = '0;
      tx_total_sum  = '0;
      rx_window_sum = '0;
      tx_window_sum = '0;
      rate_hi       = '0;
      rate_lo       = '0;

      if (ctrl.accum) begin
         if (it_tick_ff) begin
            if (elapsed_in != 32'hFFFF_FFFF)    elapsed_in    = elapsed_in + 32'd1;
            if (since_send_in != 32'hFFFF_FFFF) since_send_in = since_send_in + 32'd1;
            if (since_recv_in != 32'hFFFF_FFFF) since_recv_in = since_recv_in + 32'd1;
         end
         if (it_clear_ff) begin
            rx_total_in  = '0;
            tx_total_in  = '0;
            rx_window_in = '0;
            tx_window_in = '0;
            rx_rate_in   = '0;
            tx_rate_in   = '0;
            pressure_in  = 1'b0;
            blk_send_in  = '0;
            blk_recv_in  = '0;
         end
         rx_total_sum  = {1'b0, rx_total_in} + {33'd0, it_rxb_ff};
         rx_window_sum = {1'b0, rx_window_in} + {25'd0, it_rxb_ff};
         tx_total_sum  = {1'b0, tx_total_in} + {33'd0, it_txb_ff};
         tx_window_sum = {1'b0, tx_window_in} + {25'd0, it_txb_ff};
         if (it_rxv_ff) begin
            rx_total_in   = rx_total_sum[48] ? '1 : rx_total_sum[47:0];
            rx_window_in  = rx_window_sum[40] ? '1 : rx_window_sum[39:0];
            since_recv_in = '0;
         end
         if (it_txv_ff) begin
            tx_total_in   = tx_total_sum[48] ? '1 : tx_total_sum[47:0];
            tx_window_in  = tx_window_sum[40] ? '1 : tx_window_sum[39:0];
            since_send_in = '0;
         end
         if (it_sblk_ff && blk_send_in != 32'hFFFF_FFFF) blk_send_in = blk_send_in + 32'd1;
         if (it_rblk_ff && blk_recv_in != 32'hFFFF_FFFF) blk_recv_in = blk_recv_in + 32'd1;
         rate_due      = (it_rxv_ff || it_txv_ff) && (elapsed_in >= {16'd0, win});
         side_tx_in    = 1'b0;
         level_prod_in = 31'(it_level_ff) * PERCENT_SCALE;
         cap_prod_in   = 31'(it_cap_ff) * 31'(crit_pct_ff);
      end

      if (ctrl.mul) begin
         div_num_in = 50'(div_bytes) * RATE_SCALE;
      end

      if (ctrl.prep) begin
         div_rem_in = {14'd0, div_num_ff[49:32]};
         div_quo_in = div_num_ff[31:0];
         div_cnt_in = DIV_STEPS;
      end

      if (ctrl.div_step) begin
         div_rem_in = div_ge ? div_trial[31:0] : {div_rem_ff[30:0], div_quo_ff[31]};
         div_quo_in = {div_quo_ff[30:0], div_ge};
         div_cnt_in = div_cnt_ff - 6'd1;
      end

      if (rate_write) begin
         if (side_tx_ff) begin
            tx_rate_in   = rate_value;
            rx_window_in = '0;
            tx_window_in = '0;
            elapsed_in   = '0;
            side_tx_in   = 1'b0;
         end else begin
            rx_rate_in = rate_value;
            side_tx_in = 1'b1;
         end
      end

      if (ctrl.eval) begin
         if (it_push_ff && it_cap_ff != 24'd0) pressure_in = level_prod_ff >= cap_prod_ff;
         rate_hi      = (rx_rate_ff > tx_rate_ff) ? rx_rate_ff : tx_rate_ff;
         rate_lo      = (rx_rate_ff > tx_rate_ff) ? tx_rate_ff : rx_rate_ff;
         mis_hi_in    = {rate_hi, 4'b0000};
         mis_prod_in  = 48'(rate_lo) * 48'(mismatch_ff);
         both_zero_in = (rx_rate_ff == 32'd0) && (tx_rate_ff == 32'd0);
         one_zero_in  = (rx_rate_ff == 32'd0) || (tx_rate_ff == 32'd0);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      o_rx_rate_in  = o_rx_rate_ff;
      o_tx_rate_in  = o_tx_rate_ff;
      o_rx_total_in = o_rx_total_ff;
      o_tx_total_in = o_tx_total_ff;
      o_blk_send_in = o_blk_send_ff;
      o_blk_recv_in = o_blk_recv_ff;
      o_ovf_in      = o_ovf_ff;
      o_mis_in      = o_mis_ff;
      o_slow_in     = o_slow_ff;
      o_rgone_in    = o_rgone_ff;
      o_sgone_in    = o_sgone_ff;
      if (ctrl.emit) begin
         rsp_valid_in  = 1'b1;
         o_rx_rate_in  = rx_rate_ff;
         o_tx_rate_in  = tx_rate_ff;
         o_rx_total_in = rx_total_ff;
         o_tx_total_in = tx_total_ff;
         o_blk_send_in = blk_send_ff;
         o_blk_recv_in = blk_recv_ff;
         o_ovf_in      = pressure_ff;
         if (both_zero_ff)     o_mis_in = RATIO_ONE >= mismatch_ff;
         else if (one_zero_ff) o_mis_in = RATIO_ONE_SIDED >= mismatch_ff;
         else                  o_mis_in = {12'd0, mis_hi_ff} >= mis_prod_ff;
         o_slow_in  = (rx_rate_ff != 32'd0) && ({tx_rate_ff, 1'b0} < {1'b0, rx_rate_ff});
         o_rgone_in = (rx_total_ff != 48'd0) && (tx_total_ff == 48'd0) &&
                      (since_send_ff > disc_tmo_ff);
         o_sgone_in = (tx_total_ff != 48'd0) && (rx_total_ff == 48'd0) &&
                      (since_recv_ff > disc_tmo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rate_window_ff <= RATE_WINDOW_RST;
         crit_pct_ff    <= CRIT_PCT_RST;
         mismatch_ff    <= MISMATCH_RST;
         disc_tmo_ff    <= DISC_TMO_RST;
         rx_total_ff    <= '0;
         tx_total_ff    <= '0;
         rx_window_ff   <= '0;
         tx_window_ff   <= '0;
         rx_rate_ff     <= '0;
         tx_rate_ff     <= '0;
         elapsed_ff     <= '0;
         since_send_ff  <= '0;
         since_recv_ff  <= '0;
         pressure_ff    <= 1'b0;
         blk_send_ff    <= '0;
         blk_recv_ff    <= '0;
         side_tx_ff     <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rate_window_ff <= rate_window_in;
         crit_pct_ff    <= crit_pct_in;
         mismatch_ff    <= mismatch_in;
         disc_tmo_ff    <= disc_tmo_in;
         rx_total_ff    <= rx_total_in;
         tx_total_ff    <= tx_total_in;
         rx_window_ff   <= rx_window_in;
         tx_window_ff   <= tx_window_in;
         rx_rate_ff     <= rx_rate_in;
         tx_rate_ff     <= tx_rate_in;
         elapsed_ff     <= elapsed_in;
         since_send_ff  <= since_send_in;
         since_recv_ff  <= since_recv_in;
         pressure_ff    <= pressure_in;
         blk_send_ff    <= blk_send_in;
         blk_recv_ff    <= blk_recv_in;
         side_tx_ff     <= side_tx_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_tick_ff    <= it_tick_in;
      it_clear_ff   <= it_clear_in;
      it_rxv_ff     <= it_rxv_in;
      it_rxb_ff     <= it_rxb_in;
      it_txv_ff     <= it_txv_in;
      it_txb_ff     <= it_txb_in;
      it_push_ff    <= it_push_in;
      it_level_ff   <= it_level_in;
      it_cap_ff     <= it_cap_in;
      it_sblk_ff    <= it_sblk_in;
      it_rblk_ff    <= it_rblk_in;
      level_prod_ff <= level_prod_in;
      cap_prod_ff   <= cap_prod_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      mis_hi_ff     <= mis_hi_in;
      mis_prod_ff   <= mis_prod_in;
      both_zero_ff  <= both_zero_in;
      one_zero_ff   <= one_zero_in;
      o_rx_rate_ff  <= o_rx_rate_in;
      o_tx_rate_ff  <= o_tx_rate_in;
      o_rx_total_ff <= o_rx_total_in;
      o_tx_total_ff <= o_tx_total_in;
      o_blk_send_ff <= o_blk_send_in;
      o_blk_recv_ff <= o_blk_recv_in;
      o_ovf_ff      <= o_ovf_in;
      o_mis_ff      <= o_mis_in;
      o_slow_ff     <= o_slow_in;
      o_rgone_ff    <= o_rgone_in;
      o_sgone_ff    <= o_sgone_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_receive_rate       = o_rx_rate_ff;
   assign rsp_send_rate          = o_tx_rate_ff;
   assign rsp_total_received     = o_rx_total_ff;
   assign rsp_total_sent         = o_tx_total_ff;
   assign rsp_sends_blocked      = o_blk_send_ff;
   assign rsp_receives_blocked   = o_blk_recv_ff;
   assign rsp_overflow_flag      = o_ovf_ff;
   assign rsp_mismatch_flag      = o_mis_ff;
   assign rsp_sender_slow_flag   = o_slow_ff;
   assign rsp_receiver_gone_flag = o_rgone_ff;
   assign rsp_sender_gone_flag   = o_sgone_ff;

   `LTRM_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_ACCUM)
   `LTRM_ASSERT_NOW(a_div_rem_bound, state_ff == ST_DIV, div_rem_ff < elapsed_ff)
   `LTRM_ASSERT_NEXT(a_emit_result, ctrl.emit, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// File: tb/sv/tb_top.sv
module tb_top
   import ltrm_pkg::*;
();

   localparam logic [63:0] MS_PER_SEC      = 64'd1000;
   localparam logic [63:0] PCT_FULL        = 64'd100;
   localparam logic [63:0] SIXTEENTHS      = 64'd16;
   localparam logic [63:0] ONE_SIDED_RATIO = 64'd999;

   typedef struct packed {
      logic        tick;
      logic        clear;
      logic        rx_valid;
      logic [15:0] rx_bytes;
      logic        tx_valid;
      logic [15:0] tx_bytes;
      logic        push_valid;
      logic [23:0] buffer_level;
      logic [23:0] buffer_size;
      logic        send_blocked;
      logic        recv_blocked;
   } event_word_type;

   typedef struct packed {
      logic [31:0] receive_rate;
      logic [31:0] send_rate;
      logic [47:0] total_received;
      logic [47:0] total_sent;
      logic [31:0] sends_blocked;
      logic [31:0] receives_blocked;
      logic        overflow;
      logic        mismatch;
      logic        sender_slow;
      logic        receiver_gone;
      logic        sender_gone;
   } link_stats_type;

   typedef struct packed {
      event_word_type word;
      logic           typed;
      link_stats_type want;
   } directed_row_type;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [6:0]  crit_pct;
      logic [15:0] mismatch_16ths;
      logic [31:0] timeout_ms;
      logic [7:0]  tick_pct;
      logic [7:0]  rx_pct;
      logic [7:0]  tx_pct;
      logic [7:0]  big_pct;
      logic [15:0] words;
   } traffic_phase_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   event_word_type req_word = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   link_stats_type got;
   logic           psel = 1'b0;
   logic           penable = 1'b0;
   logic           pwrite = 1'b0;
   logic [3:0]     paddr = '0;
   logic [31:0]    pwdata = '0;
   logic [31:0]    prdata;
   logic           pready;

   // predictor configuration and state
   logic [15:0] cfg_window_ms  = RATE_WINDOW_RST;
   logic [6:0]  cfg_crit_pct   = CRIT_PCT_RST;
   logic [15:0] cfg_mismatch   = MISMATCH_RST;
   logic [31:0] cfg_timeout_ms = DISC_TMO_RST;
   logic [47:0] rx_sum = '0;
   logic [47:0] tx_sum = '0;
   logic [39:0] rx_win_bytes = '0;
   logic [39:0] tx_win_bytes = '0;
   logic [31:0] rx_rate = '0;
   logic [31:0] tx_rate = '0;
   logic [31:0] win_ms = '0;
   logic [31:0] idle_tx_ms = '0;
   logic [31:0] idle_rx_ms = '0;
   logic        buf_critical = 1'b0;
   logic [31:0] send_stalls = '0;
   logic [31:0] recv_stalls = '0;

   link_stats_type stats_due[$];
   int          mismatch_count = 0;
   int unsigned burst_left = 0;
   logic [15:0] ready_mask = 16'hFFFF;
   logic [3:0]  ready_slot = '0;

   always #5 clock = ~clock;

   link_traffic_rate_monitor_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_tick               (req_word.tick),
      .req_clear              (req_word.clear),
      .req_rx_valid           (req_word.rx_valid),
      .req_rx_bytes           (req_word.rx_bytes),
      .req_tx_valid           (req_word.tx_valid),
      .req_tx_bytes           (req_word.tx_bytes),
      .req_push_valid         (req_word.push_valid),
      .req_buffer_level       (req_word.buffer_level),
      .req_buffer_size        (req_word.buffer_size),
      .req_send_blocked       (req_word.send_blocked),
      .req_recv_blocked       (req_word.recv_blocked),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_receive_rate       (got.receive_rate),
      .rsp_send_rate          (got.send_rate),
      .rsp_total_received     (got.total_received),
      .rsp_total_sent         (got.total_sent),
      .rsp_sends_blocked      (got.sends_blocked),
      .rsp_receives_blocked   (got.receives_blocked),
      .rsp_overflow_flag      (got.overflow),
      .rsp_mismatch_flag      (got.mismatch),
      .rsp_sender_slow_flag   (got.sender_slow),
      .rsp_receiver_gone_flag (got.receiver_gone),
      .rsp_sender_gone_flag   (got.sender_gone),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, int bits);
      logic [63:0] ceiling;
      ceiling = (64'd1 << bits) - 64'd1;
      return (a + b > ceiling) ? ceiling : a + b;
   endfunction

   function automatic logic [31:0] bytes_per_sec(logic [39:0] bytes);
      logic [63:0] q;
      q = (64'(bytes) * MS_PER_SEC) / 64'(win_ms);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic link_stats_type predict_link_stats(event_word_type w);
      link_stats_type s;
      logic [31:0] span;
      logic [63:0] hi;
      logic [63:0] lo;
      if (w.tick) begin
         win_ms     = 32'(add_sat(64'(win_ms), 64'd1, 32));
         idle_tx_ms = 32'(add_sat(64'(idle_tx_ms), 64'd1, 32));
         idle_rx_ms = 32'(add_sat(64'(idle_rx_ms), 64'd1, 32));
      end
      if (w.clear) begin
         rx_sum = '0;
         tx_sum = '0;
         rx_win_bytes = '0;
         tx_win_bytes = '0;
         rx_rate = '0;
         tx_rate = '0;
         buf_critical = 1'b0;
         send_stalls = '0;
         recv_stalls = '0;
      end
      if (w.rx_valid) begin
         rx_sum       = 48'(add_sat(64'(rx_sum), 64'(w.rx_bytes), 48));
         rx_win_bytes = 40'(add_sat(64'(rx_win_bytes), 64'(w.rx_bytes), 40));
         idle_rx_ms   = '0;
      end
      if (w.tx_valid) begin
         tx_sum       = 48'(add_sat(64'(tx_sum), 64'(w.tx_bytes), 48));
         tx_win_bytes = 40'(add_sat(64'(tx_win_bytes), 64'(w.tx_bytes), 40));
         idle_tx_ms   = '0;
      end
      span = (cfg_window_ms == '0) ? 32'd1 : 32'(cfg_window_ms);
      if ((w.rx_valid || w.tx_valid) && win_ms >= span) begin
         rx_rate = bytes_per_sec(rx_win_bytes);
         tx_rate = bytes_per_sec(tx_win_bytes);
         rx_win_bytes = '0;
         tx_win_bytes = '0;
         win_ms = '0;
      end
      if (w.push_valid && w.buffer_size != '0)
         buf_critical = 64'(w.buffer_level) * PCT_FULL >=
                        64'(cfg_crit_pct) * 64'(w.buffer_size);
      if (w.send_blocked) send_stalls = 32'(add_sat(64'(send_stalls), 64'd1, 32));
      if (w.recv_blocked) recv_stalls = 32'(add_sat(64'(recv_stalls), 64'd1, 32));

      s.receive_rate     = rx_rate;
      s.send_rate        = tx_rate;
      s.total_received   = rx_sum;
      s.total_sent       = tx_sum;
      s.sends_blocked    = send_stalls;
      s.receives_blocked = recv_stalls;
      s.overflow         = buf_critical;
      hi = (rx_rate > tx_rate) ? 64'(rx_rate) : 64'(tx_rate);
      lo = (rx_rate > tx_rate) ? 64'(tx_rate) : 64'(rx_rate);
      if (hi == '0)
         s.mismatch = SIXTEENTHS >= 64'(cfg_mismatch);
      else if (lo == '0)
         s.mismatch = ONE_SIDED_RATIO * SIXTEENTHS >= 64'(cfg_mismatch);
      else
         s.mismatch = hi * SIXTEENTHS >= 64'(cfg_mismatch) * lo;
      s.sender_slow   = rx_rate != '0 && 33'(tx_rate) * 33'd2 < 33'(rx_rate);
      s.receiver_gone = rx_sum != '0 && tx_sum == '0 && idle_tx_ms > cfg_timeout_ms;
      s.sender_gone   = tx_sum != '0 && rx_sum == '0 && idle_rx_ms > cfg_timeout_ms;
      return s;
   endfunction

   function automatic event_word_type make_word(logic tick, logic clear,
         logic rxv, logic [15:0] rxb, logic txv, logic [15:0] txb,
         logic pushv, logic [23:0] level, logic [23:0] cap, logic sblk, logic rblk);
      return {tick, clear, rxv, rxb, txv, txb, pushv, level, cap, sblk, rblk};
   endfunction

   function automatic link_stats_type make_stats(logic [31:0] rr, logic [31:0] sr,
         logic [47:0] tr, logic [47:0] ts, logic [31:0] sb, logic [31:0] rb,
         logic [4:0] flags);
      return {rr, sr, tr, ts, sb, rb, flags};
   endfunction

   function automatic logic [15:0] packet_bytes(logic [7:0] big_pct);
      if ($urandom_range(0, 99) < big_pct) return 16'hFFFF;
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'($urandom_range(1, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic event_word_type random_word(traffic_phase_type p);
      event_word_type w;
      logic [95:0] noise;
      logic [63:0] scaled;
      noise = {$urandom, $urandom, $urandom};
      if ($urandom_range(0, 9) == 0) return noise[$bits(event_word_type)-1:0];
      w = '0;
      w.tick     = $urandom_range(0, 99) < p.tick_pct;
      w.clear    = $urandom_range(0, 99) < 2;
      w.rx_valid = $urandom_range(0, 99) < p.rx_pct;
      w.rx_bytes = packet_bytes(p.big_pct);
      w.tx_valid = $urandom_range(0, 99) < p.tx_pct;
      w.tx_bytes = packet_bytes(p.big_pct);
      w.push_valid = $urandom_range(0, 2) == 0;
      case ($urandom_range(0, 5))
         0: w.buffer_size = '0;
         1: w.buffer_size = 24'hFF_FFFF;
         2: w.buffer_size = 24'($urandom_range(1, 200));
         default: w.buffer_size = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: w.buffer_level = 24'($urandom);
         1: w.buffer_level = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
         default: begin
            scaled = 64'(w.buffer_size) * 64'($urandom_range(0, 130)) / PCT_FULL;
            w.buffer_level = (scaled > 64'hFF_FFFF) ? 24'hFF_FFFF : scaled[23:0];
         end
      endcase
      w.send_blocked = $urandom_range(0, 9) == 0;
      w.recv_blocked = $urandom_range(0, 9) == 0;
      return w;
   endfunction

   task automatic send_word(input event_word_type w, input link_stats_type want);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end
      end
      @(negedge clock);
      req_word  <= w;
      req_valid <= 1'b1;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      stats_due.push_back(want);
   endtask

   task automatic hold_until_settled();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (stats_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_RATE_WINDOW: cfg_window_ms  = value[15:0];
         REG_CRIT_PCT:    cfg_crit_pct   = value[6:0];
         REG_MISMATCH:    cfg_mismatch   = value[15:0];
         REG_DISC_TMO:    cfg_timeout_ms = value;
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic flag_error(input string what, input logic [63:0] want,
                             input logic [63:0] seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("error: %s expected %0h got %0h", what, want, seen);
   endtask

   // receiver stalls from a 16-bit mask, re-chosen each lap
   always @(negedge clock) begin
      if (ready_slot == 4'd15) begin
         case ($urandom_range(0, 3))
            0: ready_mask <= 16'hFFFF;
            1: ready_mask <= 16'($urandom);
            2: ready_mask <= 16'($urandom) & 16'($urandom);
            default: ready_mask <= 16'($urandom) | 16'($urandom);
         endcase
      end
      rsp_ready  <= ready_mask[ready_slot];
      ready_slot <= ready_slot + 4'd1;
   end

   always @(posedge clock) begin
      link_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (stats_due.size() == 0) begin
            flag_error("result word with nothing pending, receive_rate", '0,
                       64'(got.receive_rate));
         end else begin
            want = stats_due.pop_front();
            if (got.receive_rate !== want.receive_rate)
               flag_error("receive_rate", 64'(want.receive_rate), 64'(got.receive_rate));
            if (got.send_rate !== want.send_rate)
               flag_error("send_rate", 64'(want.send_rate), 64'(got.send_rate));
            if (got.total_received !== want.total_received)
               flag_error("total_received", 64'(want.total_received),
                          64'(got.total_received));
            if (got.total_sent !== want.total_sent)
               flag_error("total_sent", 64'(want.total_sent), 64'(got.total_sent));
            if (got.sends_blocked !== want.sends_blocked)
               flag_error("sends_blocked", 64'(want.sends_blocked),
                          64'(got.sends_blocked));
            if (got.receives_blocked !== want.receives_blocked)
               flag_error("receives_blocked", 64'(want.receives_blocked),
                          64'(got.receives_blocked));
            if (got.overflow !== want.overflow)
               flag_error("overflow_flag", 64'(want.overflow), 64'(got.overflow));
            if (got.mismatch !== want.mismatch)
               flag_error("mismatch_flag", 64'(want.mismatch), 64'(got.mismatch));
            if (got.sender_slow !== want.sender_slow)
               flag_error("sender_slow_flag", 64'(want.sender_slow),
                          64'(got.sender_slow));
            if (got.receiver_gone !== want.receiver_gone)
               flag_error("receiver_gone_flag", 64'(want.receiver_gone),
                          64'(got.receiver_gone));
            if (got.sender_gone !== want.sender_gone)
               flag_error("sender_gone_flag", 64'(want.sender_gone),
                          64'(got.sender_gone));
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      directed_row_type  directed[$];
      traffic_phase_type phases[$];
      event_word_type    w;
      link_stats_type    want;

      // at reset settings: 1000 ms window, 90 percent, 32/16 ratio, 5000 ms
      directed.push_back('{make_word(0,0,0,0,0,0,0,0,0,0,0), 1'b1,
                           make_stats(0,0,0,0,0,0,5'b00000)});
      directed.push_back('{make_word(0,0,0,0,0,0,0,0,0,1,1), 1'b1,
                           make_stats(0,0,0,0,1,1,5'b00000)});
      directed.push_back('{make_word(0,0,0,0,0,0,1,24'd89,24'd100,0,0), 1'b1,
                           make_stats(0,0,0,0,1,1,5'b00000)});
      directed.push_back('{make_word(0,0,0,0,0,0,1,24'd90,24'd100,0,0), 1'b1,
                           make_stats(0,0,0,0,1,1,5'b10000)});
      // zero capacity keeps the pressure flag
      directed.push_back('{make_word(0,0,0,0,0,0,1,24'hFFFFFF,24'd0,0,0), 1'b1,
                           make_stats(0,0,0,0,1,1,5'b10000)});
      directed.push_back('{make_word(0,1,1,16'hFFFF,0,0,0,0,0,0,0), 1'b1,
                           make_stats(0,0,48'd65535,0,0,0,5'b00000)});
      directed.push_back('{make_word(0,0,0,0,1,16'hFFFF,0,0,0,0,0), 1'b1,
                           make_stats(0,0,48'd65535,48'd65535,0,0,5'b00000)});
      directed.push_back('{make_word(1,0,1,0,1,0,0,0,0,0,0), 1'b0, '0});
      directed.push_back('{make_word(1,1,1,16'hFFFF,1,16'hFFFF,1,24'hFFFFFF,
                                     24'hFFFFFF,1,1), 1'b0, '0});
      directed.push_back('{make_word(0,0,0,16'h5555,0,16'hAAAA,1,24'h0,
                                     24'hFFFFFF,0,0), 1'b0, '0});
      directed.push_back('{make_word(1,0,1,16'hAAAA,0,16'h5555,1,24'h555555,
                                     24'hAAAAAA,0,1), 1'b0, '0});
      directed.push_back('{make_word(0,0,0,0,1,16'h5555,1,24'hAAAAAA,
                                     24'h555555,1,0), 1'b0, '0});
      directed.push_back('{make_word(1,0,0,0,0,0,1,24'd1,24'd1,0,0), 1'b0, '0});
      directed.push_back('{make_word(0,1,0,0,0,0,0,0,0,0,0), 1'b0, '0});
      directed.push_back('{make_word(1,0,1,16'd1,1,16'd0,0,0,0,0,0), 1'b0, '0});
      directed.push_back('{make_word(0,0,0,0,0,0,1,24'hFFFFFF,24'd1,0,0), 1'b0, '0});

      //                window  pct  ratio   timeout  tick rx  tx  big words
      phases.push_back('{16'd1000, 7'd90, 16'd32, 32'd5000, 8'd50, 8'd40, 8'd40,
                         8'd15, 16'd200});
      phases.push_back('{16'd1, 7'd0, 16'd0, 32'd0, 8'd20, 8'd50, 8'd50,
                         8'd15, 16'd220});
      phases.push_back('{16'd2, 7'd100, 16'd1, 32'hFFFF_FFFF, 8'd40, 8'd60, 8'd30,
                         8'd15, 16'd220});
      phases.push_back('{16'hFFFF, 7'd127, 16'hFFFF, 32'd3, 8'd50, 8'd40, 8'd0,
                         8'd15, 16'd200});
      phases.push_back('{16'd0, 7'd1, 16'd15984, 32'd0, 8'd30, 8'd0, 8'd40,
                         8'd15, 16'd200});
      phases.push_back('{16'd5, 7'd50, 16'd16, 32'd10, 8'd30, 8'd50, 8'd50,
                         8'd15, 16'd220});
      // rare ticks, big packets: drives the rates into saturation
      phases.push_back('{16'd1, 7'd90, 16'd15985, 32'd20, 8'd1, 8'd90, 8'd90,
                         8'd80, 16'd230});
      phases.push_back('{16'd3, 7'd75, 16'd48, 32'd2, 8'd60, 8'd30, 8'd30,
                         8'd15, 16'd240});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         want = predict_link_stats(directed[i].word);
         if (directed[i].typed) want = directed[i].want;
         send_word(directed[i].word, want);
      end

      foreach (phases[i]) begin
         hold_until_settled();
         repeat (4) @(negedge clock);
         write_csr(REG_RATE_WINDOW, 32'(phases[i].window_ms));
         write_csr(REG_CRIT_PCT, 32'(phases[i].crit_pct));
         write_csr(REG_MISMATCH, 32'(phases[i].mismatch_16ths));
         write_csr(REG_DISC_TMO, phases[i].timeout_ms);
         for (int n = 0; n < int'(phases[i].words); n++) begin
            if ($urandom_range(0, 149) == 0) hold_until_settled();
            w = random_word(phases[i]);
            send_word(w, predict_link_stats(w));
         end
      end

      hold_until_settled();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && stats_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: link_traffic_rate_monitor_top.f
+incdir+hw/rtl
hw/rtl/ltrm_pkg.sv
hw/rtl/link_traffic_rate_monitor_top.sv
tb/sv/tb_top.sv
